@@ rtl/qte_pkg.sv @@
// Shared widths, pipeline depths and the arctangent table for the quaternion-to-Euler pipeline.
package qte_pkg;

    localparam int QW         = 16;  // quaternion component width
    localparam int PW         = 2 * QW; // product of two components
    localparam int TW         = 34;  // atan2 arguments, Q.28
    localparam int SW         = 30;  // clamped sine of pitch, Q.28
    localparam int DW         = 58;  // square-root radicand, padded to even width
    localparam int RTW        = DW / 2; // square-root result width
    localparam int REMW       = 32;  // square-root partial remainder
    localparam int CW         = 37;  // CORDIC datapath width
    localparam int AW         = 32;  // angle accumulator, 2^32 = 2 pi
    localparam int ANGW       = 16;  // output angle width
    localparam int CSTAGES    = 30;  // CORDIC iterations
    localparam int SQ_STAGES  = RTW; // one root bit per stage

    // products, sums, square, root, CORDIC (pre-rotation + iterations), output
    localparam int LAT        = 3 + SQ_STAGES + CSTAGES + 1 + 1;
    localparam int YR_DLY     = SQ_STAGES + 1;

    localparam logic [AW-1:0] ANG_HALF_PI  = 32'h4000_0000;
    localparam logic [AW-1:0] ANG_MHALF_PI = 32'hC000_0000;
    localparam logic [AW-1:0] ANG_ROUND    = 32'h0000_8000;

    localparam logic signed [TW-1:0]   ONE_Q28   = 34'sh0_1000_0000;
    localparam logic signed [TW-1:0]   MONE_Q28  = -34'sh0_1000_0000;
    localparam logic [DW-1:0]          ONE_Q56   = 58'h100_0000_0000_0000;
    localparam logic signed [ANGW-1:0] PITCH_MAX = 16'sd16384;
    localparam logic signed [ANGW-1:0] PITCH_MIN = -16'sd16384;

    localparam logic [AW-1:0] ATAN_TAB [0:CSTAGES-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

endpackage

@@ rtl/qte_isqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
module qte_isqrt (
    input  logic                            aclk,
    input  logic                            ce,
    input  logic [qte_pkg::DW-1:0]          d_in,
    input  logic signed [qte_pkg::SW-1:0]   tag_in,
    output logic [qte_pkg::RTW-1:0]         root,
    output logic signed [qte_pkg::SW-1:0]   tag_out
);
    import qte_pkg::*;

    logic [REMW-1:0]        rem_reg  [0:SQ_STAGES-1];
    logic [RTW-1:0]         root_reg [0:SQ_STAGES-1];
    logic [DW-1:0]          v_reg    [0:SQ_STAGES-1];
    logic signed [SW-1:0]   tag_reg  [0:SQ_STAGES-1];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [REMW-1:0]      rem_prev;
        logic [RTW-1:0]       root_prev;
        logic [DW-1:0]        v_prev;
        logic signed [SW-1:0] tag_prev;
        logic [REMW-1:0]      rem_cat;
        logic [REMW-1:0]      test;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign v_prev    = d_in;
            assign tag_prev  = tag_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign v_prev    = v_reg[k-1];
            assign tag_prev  = tag_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_cat = {rem_prev[REMW-3:0], v_prev[DW-1-2*k -: 2]};
        assign test    = {{(REMW-RTW-2){1'b0}}, root_prev, 2'b01};

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (rem_cat >= test) begin
                    rem_reg[k]  <= rem_cat - test;
                    root_reg[k] <= {root_prev[RTW-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_cat;
                    root_reg[k] <= {root_prev[RTW-2:0], 1'b0};
                end
                v_reg[k]   <= v_prev;
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign root    = root_reg[SQ_STAGES-1];
    assign tag_out = tag_reg[SQ_STAGES-1];

endmodule

@@ rtl/qte_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(y, x) as a 16-bit binary angle.
module qte_cordic (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic signed [qte_pkg::CW-1:0] y_in,
    input  logic signed [qte_pkg::CW-1:0] x_in,
    output logic [qte_pkg::ANGW-1:0]      angle
);
    import qte_pkg::*;

    logic signed [CW-1:0] x_reg    [0:CSTAGES];
    logic signed [CW-1:0] y_reg    [0:CSTAGES];
    logic [AW-1:0]        acc_reg  [0:CSTAGES];
    logic                 hold_reg [0:CSTAGES];

    logic signed [CW-1:0] x_next, y_next;
    logic [AW-1:0]        acc_next;
    logic                 hold_next;
    logic [AW-1:0]        rounded;

    // pre-rotation into the right half-plane; x of zero takes a fixed angle
    always_comb begin
        x_next    = x_in;
        y_next    = y_in;
        acc_next  = '0;
        hold_next = 1'b0;
        if (x_in == '0) begin
            hold_next = 1'b1;
            if (y_in == '0) begin
                acc_next = '0;
            end else if (y_in[CW-1]) begin
                acc_next = ANG_MHALF_PI;
            end else begin
                acc_next = ANG_HALF_PI;
            end
        end else if (x_in[CW-1]) begin
            if (!y_in[CW-1]) begin
                x_next   = y_in;
                y_next   = -x_in;
                acc_next = ANG_HALF_PI;
            end else begin
                x_next   = -y_in;
                y_next   = x_in;
                acc_next = ANG_MHALF_PI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            acc_reg[0]  <= acc_next;
            hold_reg[0] <= hold_next;
        end
    end

    for (genvar i = 0; i < CSTAGES; i++) begin : g_iter
        logic signed [CW-1:0] dx, dy;
        logic                 y_pos;

        assign dx    = y_reg[i] >>> i;
        assign dy    = x_reg[i] >>> i;
        assign y_pos = !y_reg[i][CW-1] && (y_reg[i] != '0);

        always_ff @(posedge aclk) begin
            if (ce) begin
                hold_reg[i+1] <= hold_reg[i];
                if (hold_reg[i]) begin
                    x_reg[i+1]   <= x_reg[i];
                    y_reg[i+1]   <= y_reg[i];
                    acc_reg[i+1] <= acc_reg[i];
                end else if (y_pos) begin
                    x_reg[i+1]   <= x_reg[i] + dx;
                    y_reg[i+1]   <= y_reg[i] - dy;
                    acc_reg[i+1] <= acc_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1]   <= x_reg[i] - dx;
                    y_reg[i+1]   <= y_reg[i] + dy;
                    acc_reg[i+1] <= acc_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign rounded = acc_reg[CSTAGES] + ANG_ROUND;
    assign angle   = rounded[AW-1 -: ANGW];

endmodule

@@ rtl/quaternion_to_euler_angles.sv @@
// Quaternion (Q1.14) to ZYX yaw, pitch and roll binary angles, fully pipelined.
// Stages from request acceptance to result valid: products, sums, pitch square,
// 29 square-root stages, 31 CORDIC stages, output register.
// Throughput: one request per cycle; the whole pipeline holds while the result waits.
// Reset: aresetn (synchronous, active low) clears the valid bits; data registers keep.
module quaternion_to_euler_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32]
);
    import qte_pkg::*;

    logic ce;

    // working axes: x takes the incoming z component and z the incoming x
    logic signed [QW-1:0] ax, ay, az, aw;

    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, zz_reg;

    logic signed [TW-1:0] t0_next, t1_next, t2_next, t3_next, t4_next;
    logic signed [TW-1:0] t0_reg, t1_reg, t3_reg, t4_reg;
    logic signed [SW-1:0] s_next, s_reg, s3_reg;

    logic signed [2*SW-1:0] sq;
    logic [DW-1:0]          d_reg;

    logic [RTW-1:0]       cos_root;
    logic signed [SW-1:0] sin_dly;

    logic [ANGW-1:0] yaw_raw, roll_raw, pitch_raw;
    logic [ANGW-1:0] yaw_dly_reg  [0:YR_DLY-1];
    logic [ANGW-1:0] roll_dly_reg [0:YR_DLY-1];
    logic signed [ANGW-1:0] pitch_sgn, pitch_clamped;

    logic [LAT-1:1] vld_reg;
    logic           m_tvalid_reg;
    logic [47:0]    m_tdata_reg;

    // advance everything when the output register is free or being emptied
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    assign az = s_tdata[15:0];
    assign ay = s_tdata[31:16];
    assign ax = s_tdata[47:32];
    assign aw = s_tdata[63:48];

    // stage 1: component products
    always_ff @(posedge aclk) begin
        if (ce) begin
            wx_reg <= aw * ax;
            yz_reg <= ay * az;
            xx_reg <= ax * ax;
            yy_reg <= ay * ay;
            wy_reg <= aw * ay;
            zx_reg <= az * ax;
            wz_reg <= aw * az;
            xy_reg <= ax * ay;
            zz_reg <= az * az;
        end
    end

    // stage 2: atan2 arguments in Q.28, sine of pitch clamped to unity
    always_comb begin
        t0_next = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        t1_next = ONE_Q28 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        t2_next = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        t3_next = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        t4_next = ONE_Q28 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        if (t2_next > ONE_Q28) begin
            s_next = SW'(ONE_Q28);
        end else if (t2_next < MONE_Q28) begin
            s_next = SW'(MONE_Q28);
        end else begin
            s_next = t2_next[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
            s_reg  <= s_next;
        end
    end

    // stage 3: radicand 2^56 - s^2 for the pitch cosine
    assign sq = s_reg * s_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg  <= ONE_Q56 - sq[DW-1:0];
            s3_reg <= s_reg;
        end
    end

    qte_isqrt u_isqrt (
        .aclk    (aclk),
        .ce      (ce),
        .d_in    (d_reg),
        .tag_in  (s3_reg),
        .root    (cos_root),
        .tag_out (sin_dly)
    );

    qte_cordic u_pitch (
        .aclk  (aclk),
        .ce    (ce),
        .y_in  (CW'(sin_dly)),
        .x_in  ($signed({{(CW-RTW){1'b0}}, cos_root})),
        .angle (pitch_raw)
    );

    qte_cordic u_yaw (
        .aclk  (aclk),
        .ce    (ce),
        .y_in  (CW'(t3_reg)),
        .x_in  (CW'(t4_reg)),
        .angle (yaw_raw)
    );

    qte_cordic u_roll (
        .aclk  (aclk),
        .ce    (ce),
        .y_in  (CW'(t0_reg)),
        .x_in  (CW'(t1_reg)),
        .angle (roll_raw)
    );

    // hold yaw and roll back until pitch has been through the square root
    always_ff @(posedge aclk) begin
        if (ce) begin
            yaw_dly_reg[0]  <= yaw_raw;
            roll_dly_reg[0] <= roll_raw;
            for (int i = 1; i < YR_DLY; i++) begin
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
                roll_dly_reg[i] <= roll_dly_reg[i-1];
            end
        end
    end

    // clamp pitch to a quarter turn either way
    assign pitch_sgn = pitch_raw;

    always_comb begin
        if (pitch_sgn > PITCH_MAX) begin
            pitch_clamped = PITCH_MAX;
        end else if (pitch_sgn < PITCH_MIN) begin
            pitch_clamped = PITCH_MIN;
        end else begin
            pitch_clamped = pitch_sgn;
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg      <= {vld_reg[LAT-2:1], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {roll_dly_reg[YR_DLY-1], pitch_clamped, yaw_dly_reg[YR_DLY-1]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // pitch never leaves a quarter turn
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= PITCH_MAX &&
                      $signed(m_tdata[31:16]) >= PITCH_MIN))
        else $error("pitch result outside quarter turn");

    // a stalled pipeline keeps every in-flight request
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    // the last stage lands in the output register when the pipe advances
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (ce && vld_reg[LAT-1]) |=> m_tvalid)
        else $error("request lost at output register");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the quaternion to yaw, pitch and roll angle pipeline.
`timescale 1ns / 1ps

module testbench;
    import qte_pkg::*;

    localparam int IDLE_LIMIT = 5000;   // cycles with no request or result accepted
    localparam int HOLD_LEN   = 400;    // long receiver hold-off, well past the pipe depth
    localparam int N_RANDOM   = 1900;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } euler_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32]

    quat_t  quat_pending[$];    // requests not yet offered
    euler_t angles_due[$];      // predicted angles, oldest first
    int     phase;              // 0: sender light / receiver heavy idling, 1: swapped, 2: none
    int     req_count;          // requests accepted, owned by the monitor
    int     req_seen;           // driver's copy of req_count
    int     idle_cycles;
    int     hold_left;
    bit     hold_arm;
    bit     hold_done;
    bit     failed;

    quaternion_to_euler_angles dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Angle prediction
    // ---------------------------------------------------------------

    // Integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC: atan2(y, x) as a 32-bit binary angle
    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        longint      t;
        longint      dx;
        longint      dy;
        acc = '0;
        if (x == 0) begin
            if (y > 0) return ANG_HALF_PI;
            if (y < 0) return ANG_MHALF_PI;
            return '0;
        end
        // fold the left half-plane onto the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; acc = ANG_HALF_PI;
            end else begin
                x = -y; y = t; acc = ANG_MHALF_PI;
            end
        end
        for (int i = 0; i < CSTAGES; i++) begin
            dx = y >>> i;   // arithmetic shift floors
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; acc = acc + ATAN_TAB[i];
            end else begin
                x = x - dx; y = y + dy; acc = acc - ATAN_TAB[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] round_angle(logic [31:0] a);
        logic [31:0] r;
        r = a + ANG_ROUND;
        return r[31:16];
    endfunction

    function automatic euler_t predict_angles(quat_t q);
        longint one;
        longint qx, qy, qz, qw;
        longint roll_n, roll_d, sin_p, yaw_n, yaw_d;
        longint unsigned cos_p;
        logic signed [15:0] p;
        euler_t e;
        one = 64'sd1 <<< 28;
        // axes are swapped: working x is quat_z, working z is quat_x
        qx = q.z; qy = q.y; qz = q.x; qw = q.w;
        roll_n = 2 * (qw * qx + qy * qz);
        roll_d = one - 2 * (qx * qx + qy * qy);
        sin_p  = 2 * (qw * qy - qz * qx);
        yaw_n  = 2 * (qw * qz + qx * qy);
        yaw_d  = one - 2 * (qy * qy + qz * qz);
        if (sin_p > one) sin_p = one;
        if (sin_p < -one) sin_p = -one;
        cos_p = floor_sqrt((64'd1 << 56) - longint'(sin_p * sin_p));
        p = round_angle(vector_angle(sin_p, longint'(cos_p)));
        if (p > PITCH_MAX) p = PITCH_MAX;
        if (p < PITCH_MIN) p = PITCH_MIN;
        e.yaw   = round_angle(vector_angle(yaw_n, yaw_d));
        e.pitch = p;
        e.roll  = round_angle(vector_angle(roll_n, roll_d));
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic quat_t make_quat(int x, int y, int z, int w);
        quat_t q;
        q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
        return q;
    endfunction

    function automatic int rand_comp();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    // Random unit quaternion; gimbal-lock neighbourhood now and then
    function automatic quat_t unit_quat();
        real c[4];
        real n;
        int  k;
        k = $urandom_range(9);
        for (int i = 0; i < 4; i++) c[i] = real'(rand_comp());
        if (k == 0) begin
            // drive 2(wy - zx) close to +/-1
            c[1] = 11585.0 + real'($urandom_range(400)) - 200.0;
            c[3] = ($urandom_range(1) != 0) ? c[1] : -c[1];
            c[0] = real'($urandom_range(200)) - 100.0;
            c[2] = real'($urandom_range(200)) - 100.0;
        end
        n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        if (n < 1.0) return make_quat(0, 0, 0, 16384);
        return make_quat(int'(c[0] * 16384.0 / n), int'(c[1] * 16384.0 / n),
                         int'(c[2] * 16384.0 / n), int'(c[3] * 16384.0 / n));
    endfunction

    function automatic quat_t random_quat();
        int k;
        k = $urandom_range(99);
        if (k < 80) return unit_quat();
        if (k < 90) return make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        return quat_t'({$urandom, $urandom});   // any bit pattern, out of range too
    endfunction

    task automatic queue_directed();
        quat_pending.push_back(make_quat(0, 0, 0, 16384));          // identity
        quat_pending.push_back(make_quat(0, 0, 0, -16384));
        quat_pending.push_back(make_quat(16384, 0, 0, 0));
        quat_pending.push_back(make_quat(0, 16384, 0, 0));
        quat_pending.push_back(make_quat(0, 0, 16384, 0));          // roll of pi, wraps
        quat_pending.push_back(make_quat(-16384, -16384, -16384, -16384));
        quat_pending.push_back(make_quat(16384, 16384, 16384, 16384));
        quat_pending.push_back(make_quat(0, 11585, 0, 11585));      // pitch at +pi/2
        quat_pending.push_back(make_quat(0, 11585, 0, -11585));     // pitch at -pi/2
        quat_pending.push_back(make_quat(16384, 16384, 0, 0));      // sine of pitch zero
        quat_pending.push_back(make_quat(8192, 8192, 0, 0));        // yaw atan2(0, 0)
        quat_pending.push_back(make_quat(8192, 8192, 0, 8192));     // yaw denominator zero
        quat_pending.push_back(make_quat(0, 0, 0, 0));              // zero quaternion, all numerators zero
        quat_pending.push_back(make_quat(-32768, -32768, -32768, -32768));
        quat_pending.push_back(make_quat(32767, 32767, 32767, 32767));
        quat_pending.push_back(make_quat(32767, -32768, 21845, -21846));
        quat_pending.push_back(make_quat(8192, -8192, 8192, -8192));
        quat_pending.push_back(make_quat(-11585, 0, 11585, 0));
    endtask

    task automatic drain_pending();
        while (quat_pending.size() != 0 || s_tvalid) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Driver: offer requests at the falling edge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        int idle_pct;
        idle_pct = (phase == 0) ? 16 : (phase == 1) ? 70 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            req_seen <= 0;
        end else if (!s_tvalid || req_count != req_seen) begin
            // previous request gone: load the next one or idle
            req_seen <= req_count;
            if (quat_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= quat_pending.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off
    always @(negedge aclk) begin
        int idle_pct;
        idle_pct = (phase == 0) ? 70 : (phase == 1) ? 16 : 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on each request, check each result
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        euler_t got;
        euler_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (angles_due.size() == 0) begin
                    $display("%0t: result with none due: %h", $time, m_tdata);
                    failed = 1'b1;
                end else begin
                    want = angles_due.pop_front();
                    if (got.yaw !== want.yaw) begin
                        $display("%0t: yaw expected %0d got %0d", $time, want.yaw, got.yaw);
                        failed = 1'b1;
                    end
                    if (got.pitch !== want.pitch) begin
                        $display("%0t: pitch expected %0d got %0d",
                                 $time, want.pitch, got.pitch);
                        failed = 1'b1;
                    end
                    if (got.roll !== want.roll) begin
                        $display("%0t: roll expected %0d got %0d",
                                 $time, want.roll, got.roll);
                        failed = 1'b1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                angles_due.push_back(predict_angles(quat_t'(s_tdata)));
                req_count <= req_count + 1;
            end
        end
    end

    // Watchdog: stop if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** quaternion_to_euler_angles: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        failed      = 1'b0;
        phase       = 0;
        req_count   = 0;
        idle_cycles = 0;
        hold_left   = 0;
        hold_arm    = 1'b0;
        hold_done   = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        queue_directed();
        for (int i = 0; i < N_RANDOM / 3; i++) quat_pending.push_back(random_quat());
        drain_pending();

        phase = 1;
        for (int i = 0; i < N_RANDOM / 3; i++) quat_pending.push_back(random_quat());
        drain_pending();

        // no idling; hold the receiver long enough to fill the pipe and stall input
        phase    = 2;
        hold_arm = 1'b1;
        for (int i = 0; i < N_RANDOM / 3; i++) quat_pending.push_back(random_quat());
        drain_pending();

        while (angles_due.size() != 0) @(posedge aclk);
        repeat (LAT + 20) @(posedge aclk);
        if (!failed && angles_due.size() == 0) begin
            $display("** quaternion_to_euler_angles: PASSED **");
        end else begin
            $display("** quaternion_to_euler_angles: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/qte_pkg.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles.sv
test/testbench.sv
